>>> rtl/ecpm_pkg.sv
package ecpm_pkg;

	// scale factor from units to microjoules and from microjoules to power
	localparam int UjW = 20;
	localparam logic [UjW-1:0] UJ_PER_UNIT = 20'd1000000;

	localparam int CntW = 32;
	localparam int TimeW = 64;
	localparam int EnergyW = 52;
	localparam int PowerW = 32;
	localparam int StatusW = 2;
	localparam int ShiftW = 5;

	// half of the microjoule delta per partial product
	localparam int HalfW = EnergyW / 2;
	localparam int PartW = HalfW + UjW;
	localparam int NumW = EnergyW + UjW;
	localparam int DivCntW = $clog2(NumW);

	localparam logic [ShiftW-1:0] SHIFT_RESET = 5'd14;

	// status codes
	localparam logic [StatusW-1:0] ST_OK = 2'd0;
	localparam logic [StatusW-1:0] ST_PRIME = 2'd1;
	localparam logic [StatusW-1:0] ST_ZERO_DT = 2'd2;

	// register byte addresses
	localparam logic [2:0] REG_UNIT_SHIFT = 3'd0;

	typedef struct packed {
		logic load;
		logic mul;
		logic scale;
		logic mul_lo;
		logic mul_hi;
		logic acc;
		logic div_step;
		logic emit;
	} ecpm_cmd_t;

	typedef struct packed {
		logic no_power;
		logic div_done;
		logic out_free;
	} ecpm_stat_t;

endpackage

>>> rtl/ecpm_ctrl.sv
module ecpm_ctrl
	import ecpm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  ecpm_stat_t stat,
	output ecpm_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_MUL    = 3'd1;
	localparam logic [2:0] S_SCALE  = 3'd2;
	localparam logic [2:0] S_MUL_LO = 3'd3;
	localparam logic [2:0] S_MUL_HI = 3'd4;
	localparam logic [2:0] S_ACC    = 3'd5;
	localparam logic [2:0] S_DIV    = 3'd6;
	localparam logic [2:0] S_EMIT   = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_nx;

	assign in_ready = (state_q == S_IDLE);

	// next state and commands
	always_comb begin
		state_nx = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_nx = S_SCALE;
			end
			S_SCALE: begin
				cmd.scale = 1'b1;
				state_nx = stat.no_power ? S_EMIT : S_MUL_LO;
			end
			S_MUL_LO: begin
				cmd.mul_lo = 1'b1;
				state_nx = S_MUL_HI;
			end
			S_MUL_HI: begin
				cmd.mul_hi = 1'b1;
				state_nx = S_ACC;
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				state_nx = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_done) state_nx = S_EMIT;
			end
			S_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_nx;
	end

endmodule

>>> rtl/ecpm_dpath.sv
module ecpm_dpath
	import ecpm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  ecpm_cmd_t          cmd,
	output ecpm_stat_t         stat,
	input  logic [ShiftW-1:0]  unit_shift,
	input  logic [CntW-1:0]    counter_raw,
	input  logic [TimeW-1:0]   sample_time_ns,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [EnergyW-1:0] energy_microjoules,
	output logic [PowerW-1:0]  power_milliwatts,
	output logic [StatusW-1:0] status
);

	// state kept between samples
	logic [CntW-1:0]  prev_cnt_q;
	logic [TimeW-1:0] prev_time_q;
	logic             have_prev_q;

	// per-item working registers
	logic [CntW-1:0]    cnt_q;
	logic [CntW-1:0]    dcnt_q;
	logic [TimeW-1:0]   dt_q;
	logic [StatusW-1:0] status_q;
	logic               no_power_q;
	logic [EnergyW-1:0] prod_e_q;
	logic [EnergyW-1:0] prod_d_q;
	logic [EnergyW-1:0] energy_q;
	logic [EnergyW-1:0] uj_q;
	logic [PartW-1:0]   pp_q;
	logic [NumW-1:0]    num_q;
	logic [TimeW-1:0]   rem_q;
	logic [PowerW-1:0]  quo_q;
	logic               sat_q;
	logic [DivCntW-1:0] div_cnt_q;

	// output register
	logic               out_valid_q;
	logic [EnergyW-1:0] out_energy_q;
	logic [PowerW-1:0]  out_power_q;
	logic [StatusW-1:0] out_status_q;

	logic [TimeW-1:0] dt_nx;
	logic [TimeW:0]   rem_sh;
	logic [TimeW:0]   rem_diff;
	logic             ge;

	assign dt_nx = sample_time_ns - prev_time_q;

	// one restoring division step
	assign rem_sh = {rem_q, num_q[NumW-1]};
	assign rem_diff = rem_sh - {1'b0, dt_q};
	assign ge = !rem_diff[TimeW];

	assign stat.no_power = no_power_q;
	assign stat.div_done = (div_cnt_q == '0);
	assign stat.out_free = !out_valid_q || out_ready;

	// sample state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_cnt_q <= '0;
			prev_time_q <= '0;
			have_prev_q <= 1'b0;
		end else if (cmd.load) begin
			prev_cnt_q <= counter_raw;
			prev_time_q <= sample_time_ns;
			have_prev_q <= 1'b1;
		end
	end

	// capture, multiply, scale and divide
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cnt_q <= counter_raw;
			dcnt_q <= counter_raw - prev_cnt_q;
			dt_q <= dt_nx;
			no_power_q <= !have_prev_q || (dt_nx == '0);
			if (!have_prev_q) status_q <= ST_PRIME;
			else if (dt_nx == '0) status_q <= ST_ZERO_DT;
			else status_q <= ST_OK;
		end
		if (cmd.mul) begin
			prod_e_q <= {{UjW{1'b0}}, cnt_q} * {{CntW{1'b0}}, UJ_PER_UNIT};
			prod_d_q <= {{UjW{1'b0}}, dcnt_q} * {{CntW{1'b0}}, UJ_PER_UNIT};
		end
		if (cmd.scale) begin
			energy_q <= prod_e_q >> unit_shift;
			uj_q <= prod_d_q >> unit_shift;
		end
		if (cmd.mul_lo) begin
			pp_q <= {{UjW{1'b0}}, uj_q[HalfW-1:0]} * {{HalfW{1'b0}}, UJ_PER_UNIT};
		end
		if (cmd.mul_hi) begin
			num_q <= {{(NumW-PartW){1'b0}}, pp_q};
			pp_q <= {{UjW{1'b0}}, uj_q[EnergyW-1:HalfW]} * {{HalfW{1'b0}}, UJ_PER_UNIT};
		end
		if (cmd.acc) begin
			num_q <= num_q + {pp_q, {HalfW{1'b0}}};
			rem_q <= '0;
			quo_q <= '0;
			sat_q <= 1'b0;
			div_cnt_q <= DivCntW'(NumW - 1);
		end
		if (cmd.div_step) begin
			num_q <= {num_q[NumW-2:0], 1'b0};
			rem_q <= ge ? rem_diff[TimeW-1:0] : rem_sh[TimeW-1:0];
			quo_q <= {quo_q[PowerW-2:0], ge};
			// a quotient bit above bit 31 means saturation
			if (ge && (div_cnt_q >= DivCntW'(PowerW))) sat_q <= 1'b1;
			div_cnt_q <= div_cnt_q - DivCntW'(1);
		end
	end

	// result register, frees the controller while the result waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.emit) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_energy_q <= energy_q;
			out_status_q <= status_q;
			if (no_power_q) out_power_q <= '0;
			else if (sat_q) out_power_q <= '1;
			else out_power_q <= quo_q;
		end
	end

	assign out_valid = out_valid_q;
	assign energy_microjoules = out_energy_q;
	assign power_milliwatts = out_power_q;
	assign status = out_status_q;

endmodule

>>> rtl/energy_counter_power_meter_top.sv
// channel  | group            | contents
// ---------+------------------+----------------------------------------------
// input    | s_tvalid/tready  | s_tdata: counter_raw, sample_time_ns
// output   | m_tvalid/tready  | m_tdata: energy_microjoules, power_milliwatts
//          |                  | m_tuser: status
// config   | apb              | 0x0: energy_unit_shift (5 bits)
//
// when power is computed, one sample runs from transfer through one multiply step
// for both products, scale, three steps for the 52x20 product, 72 steps of the
// restoring divider and the result; otherwise scale goes straight to the result.
// the divider loop sets the rate; one sample is in work at a time, and the
// next transfer can come in the cycle after the result is loaded.
// reset clears the stored sample and sets the unit shift to 14.
// a stalled result sits in the output register; the next sample is taken
// and worked on meanwhile, and waits only to hand over its result.
module energy_counter_power_meter_top
	import ecpm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// [31:0] counter_raw, [95:32] sample_time_ns
	input  logic [95:0] s_tdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [51:0] energy_microjoules, [83:52] power_milliwatts, [87:84] zero
	output logic [87:0] m_tdata,
	// [1:0] status
	output logic [1:0]  m_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	ecpm_cmd_t  cmd;
	ecpm_stat_t stat;

	logic [ShiftW-1:0]  shift_q;
	logic [EnergyW-1:0] energy;
	logic [PowerW-1:0]  power;
	logic               sel_shift;

	// register decode on word address
	assign pready = 1'b1;
	assign sel_shift = (paddr[2] == REG_UNIT_SHIFT[2]);
	assign prdata = sel_shift ? {{(32-ShiftW){1'b0}}, shift_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) shift_q <= SHIFT_RESET;
		else if (psel && penable && pwrite && pready && sel_shift) shift_q <= pwdata[ShiftW-1:0];
	end

	ecpm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	ecpm_dpath u_dpath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.unit_shift        (shift_q),
		.counter_raw       (s_tdata[31:0]),
		.sample_time_ns    (s_tdata[95:32]),
		.out_valid         (m_tvalid),
		.out_ready         (m_tready),
		.energy_microjoules(energy),
		.power_milliwatts  (power),
		.status            (m_tuser)
	);

	assign m_tdata = {4'b0, power, energy};

endmodule

>>> rtl/ecpm_checker.sv
module ecpm_checker
	import ecpm_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [87:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tvalid,
	input logic        m_tready
);

	// one sample in work at a time
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken while a sample is in work");

	// a result never shows up the cycle after its sample transfer
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !$rose(m_tvalid))
		else $error("result appeared too early");

	// power is zero unless the status says valid
	a_power_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != ST_OK) |-> (m_tdata[83:52] == '0))
		else $error("power nonzero with non-ok status");

	// status stays within its codes
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_PRIME || m_tuser == ST_ZERO_DT))
		else $error("unknown status code");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled result changed");

endmodule

bind energy_counter_power_meter_top ecpm_checker u_ecpm_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready)
);

>>> tb/tb_top.sv
module tb_top;
	import ecpm_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_AT_SAMPLE = 300;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_PER_PHASE = 180;

	// one sample as it travels on s_tdata: count in the low bits
	typedef struct packed {
		logic [63:0] when_ns;
		logic [31:0] count;
	} sample_t;

	typedef struct packed {
		logic [51:0] energy;
		logic [31:0] power;
		logic [1:0]  status;
	} meter_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic [95:0] s_tdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [87:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	energy_counter_power_meter_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// samples waiting to go out and readings waiting to come back
	sample_t       sample_q[$];
	meter_result_t reading_q[$];

	// meter state as the block should hold it
	logic [4:0]  shift_cfg = SHIFT_RESET;
	logic [31:0] prev_count = '0;
	logic [63:0] prev_time = '0;
	logic        have_prev = 1'b0;

	// sample generator state
	logic [31:0] gen_count = '0;
	logic [63:0] gen_time = '0;

	logic idle_on = 1'b1;
	int   errors = 0;
	int   samples_in = 0;
	int   hold_left = 0;
	logic hold_done = 1'b0;
	int   tx_gap = 0;
	int   rx_gap = 0;
	int   cycle_count = 0;

	// counter units to microjoules
	function automatic logic [51:0] count_to_uj(logic [31:0] units, logic [4:0] shift);
		logic [63:0] prod;
		prod = {32'd0, units} * {44'd0, UJ_PER_UNIT};
		return prod[51:0] >> shift;
	endfunction

	// microjoules over nanoseconds, scaled to milliwatts and saturated
	function automatic logic [31:0] avg_power_mw(logic [51:0] uj, logic [63:0] dt);
		logic [127:0] num;
		logic [127:0] quo;
		num = {76'd0, uj} * {108'd0, UJ_PER_UNIT};
		quo = num / {64'd0, dt};
		return (quo > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
	endfunction

	// reading for one accepted sample; advances the stored sample
	function automatic meter_result_t next_reading(sample_t smp);
		meter_result_t r;
		logic [31:0] d_units;
		logic [63:0] dt;
		r.energy = count_to_uj(smp.count, shift_cfg);
		r.power = '0;
		if (!have_prev) begin
			r.status = ST_PRIME;
		end else begin
			d_units = smp.count - prev_count;
			dt = smp.when_ns - prev_time;
			if (dt == 64'd0) begin
				r.status = ST_ZERO_DT;
			end else begin
				r.status = ST_OK;
				r.power = avg_power_mw(count_to_uj(d_units, shift_cfg), dt);
			end
		end
		prev_count = smp.count;
		prev_time = smp.when_ns;
		have_prev = 1'b1;
		return r;
	endfunction

	task automatic queue_sample(logic [31:0] count, logic [63:0] when_ns);
		sample_t smp;
		smp.count = count;
		smp.when_ns = when_ns;
		sample_q.push_back(smp);
		gen_count = count;
		gen_time = when_ns;
	endtask

	// mostly plausible counter readings, with stalls, jumps and noise mixed in
	task automatic queue_random(int n);
		logic [31:0] c;
		logic [63:0] t;
		int kind;
		for (int i = 0; i < n; i++) begin
			kind = $urandom_range(0, 19);
			c = gen_count;
			t = gen_time;
			case (kind)
				0: begin
					c = c + $urandom_range(0, 32'h0001_0000);
				end
				1: begin
					c = $urandom;
					t = {$urandom, $urandom};
				end
				2: begin
					c = c + $urandom_range(0, 32'h0001_0000);
					t = t - $urandom_range(1, 100000);
				end
				3: begin
					c = c + $urandom;
					t = t + $urandom_range(1, 16);
				end
				4: begin
					c = c + $urandom;
					t = t + {$urandom_range(0, 255), $urandom};
				end
				5: begin
					c = c + $urandom_range(0, 32'h0100_0000);
					t = t + $urandom_range(1, 1000);
				end
				default: begin
					c = c + $urandom_range(0, 32'h0010_0000);
					t = t + $urandom_range(1000, 100000000);
				end
			endcase
			queue_sample(c, t);
		end
	endtask

	// register write, setup then access phase
	task automatic write_unit_shift(logic [4:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_UNIT_SHIFT;
		pwdata <= {27'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		shift_cfg = value;
	endtask

	// wait until every queued sample went in and every reading came out
	task automatic drain();
		while (sample_q.size() != 0 || s_tvalid || reading_q.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// sample driver
	always @(posedge clk or negedge arst_n) begin : sample_driver
		logic offer;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			tx_gap = 0;
		end else begin
			offer = s_tvalid;
			if (s_tvalid && s_tready) begin
				reading_q.push_back(next_reading(sample_t'(s_tdata)));
				samples_in <= samples_in + 1;
				offer = 1'b0;
			end
			if (!offer && sample_q.size() != 0) begin
				if (tx_gap != 0) begin
					tx_gap--;
				end else if (idle_on && $urandom_range(0, 4) == 0) begin
					tx_gap = $urandom_range(0, 3);
				end else begin
					s_tdata <= sample_q.pop_front();
					offer = 1'b1;
				end
			end
			s_tvalid <= offer;
		end
	end

	// long output hold-off once, while samples keep coming
	always @(posedge clk or negedge arst_n) begin : output_hold
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && samples_in == HOLD_AT_SAMPLE) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// result monitor and ready generation
	always @(posedge clk or negedge arst_n) begin : reading_monitor
		meter_result_t want;
		logic ready;
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_gap = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (reading_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, got tdata %h tuser %0d",
						$time, m_tdata, m_tuser);
					errors++;
				end else begin
					want = reading_q.pop_front();
					if (m_tdata[51:0] !== want.energy) begin
						$display("%0t: energy_microjoules expected %0d got %0d",
							$time, want.energy, m_tdata[51:0]);
						errors++;
					end
					if (m_tdata[83:52] !== want.power) begin
						$display("%0t: power_milliwatts expected %0d got %0d",
							$time, want.power, m_tdata[83:52]);
						errors++;
					end
					if (m_tuser !== want.status) begin
						$display("%0t: status expected %0d got %0d",
							$time, want.status, m_tuser);
						errors++;
					end
					if (m_tdata[87:84] !== 4'd0) begin
						$display("%0t: tdata padding expected 0 got %h",
							$time, m_tdata[87:84]);
						errors++;
					end
				end
			end
			if (hold_left != 0) begin
				ready = 1'b0;
			end else if (rx_gap != 0) begin
				rx_gap--;
				ready = 1'b0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				rx_gap = $urandom_range(0, 3);
				ready = 1'b0;
			end else begin
				ready = 1'b1;
			end
			m_tready <= ready;
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("energy_counter_power_meter_top test failed");
			$finish;
		end
	end

	// stimulus sequence
	initial begin : stimulus
		logic [4:0] phase_shift;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset shift: priming, zero interval, saturation, wraps, time going back
		queue_sample(32'h0000_0000, 64'd0);
		queue_sample(32'h0000_0000, 64'd0);
		queue_sample(32'hFFFF_FFFF, 64'd1);
		queue_sample(32'hFFFF_FFF0, 64'd1001);
		queue_sample(32'h0000_0010, 64'd2001);
		queue_sample(32'h0000_0010, 64'd1001);
		queue_sample(32'h0000_07D0, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_sample(32'h0000_0BB8, 64'd0);
		queue_sample(32'h0012_D687, 64'd50000000);
		drain();

		// no shift: largest energy and a saturating interval of one
		write_unit_shift(5'd0);
		queue_sample(32'hFFFF_FFFF, 64'd60000000);
		queue_sample(32'h0000_0000, 64'd60000001);
		queue_sample(32'h000F_4240, 64'd80000000);
		drain();

		// widest shift
		write_unit_shift(5'd31);
		queue_sample(32'hFFFF_FFFF, 64'd90000000);
		queue_sample(32'h7FFF_FFFF, 64'd90000000);
		queue_sample(32'h89AB_CDEF, 64'd190000000);
		drain();

		// random phases at several shifts; last one without idling
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: phase_shift = 5'd0;
				1: phase_shift = 5'd31;
				2: phase_shift = SHIFT_RESET;
				default: phase_shift = 5'($urandom_range(0, 31));
			endcase
			write_unit_shift(phase_shift);
			if (phase == 5)
				idle_on <= 1'b0;
			queue_random(RANDOM_PER_PHASE);
			drain();
		end

		repeat (100) @(posedge clk);
		if (errors == 0 && reading_q.size() == 0) begin
			$display("energy_counter_power_meter_top test passed");
		end else begin
			$display("energy_counter_power_meter_top test failed");
		end
		$finish;
	end

endmodule
